### hw/rtl/twb_pkg.sv
// shared types, constants and lane helpers for the transactional write buffer
`timescale 1ns / 1ps

package twb_pkg;

  localparam int BADDR_W     = 48;
  localparam int WADDR_W     = 45;
  localparam int DATA_W      = 64;
  localparam int FILT_W      = 32;
  localparam int FILT_IDX_W  = 5;
  localparam int IN_TDATA_W  = 184;
  localparam int OUT_TDATA_W = 240;
  localparam int OUT_TUSER_W = 4;

  // output tuser bit positions
  localparam int TU_HIT   = 0;
  localparam int TU_MAYBE = 1;
  localparam int TU_DROP  = 2;
  localparam int TU_EMPTY = 3;

  typedef enum logic [1:0] {
    MODE_STORE  = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_COMMIT = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2,
    SIZE_DBL  = 2'd3
  } size_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_LOAD_INIT,
    ST_LOAD_CMP,
    ST_DRAIN,
    ST_EMPTY,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic [WADDR_W-1:0] addr;
    logic [DATA_W-1:0]  value;
    logic [DATA_W-1:0]  mask;
  } entry_t;

  // filter index of the word holding a byte address
  function automatic logic [FILT_IDX_W-1:0] filter_idx(input logic [BADDR_W-1:0] baddr);
    filter_idx = {baddr[6:3], 1'b0} ^ baddr[9:5];
  endfunction

  // lane shift in bits, offset rounded down to natural alignment
  function automatic logic [5:0] lane_shift(input logic [2:0] off, input size_e size);
    case (size)
      SIZE_BYTE: lane_shift = {off, 3'b000};
      SIZE_HALF: lane_shift = {off[2:1], 4'b0000};
      SIZE_WORD: lane_shift = {off[2], 5'b00000};
      SIZE_DBL:  lane_shift = 6'd0;
      default:   lane_shift = 6'd0;
    endcase
  endfunction

  // unshifted data mask for an access size
  function automatic logic [DATA_W-1:0] data_mask(input size_e size);
    case (size)
      SIZE_BYTE: data_mask = 64'h0000_0000_0000_00FF;
      SIZE_HALF: data_mask = 64'h0000_0000_0000_FFFF;
      SIZE_WORD: data_mask = 64'h0000_0000_FFFF_FFFF;
      SIZE_DBL:  data_mask = '1;
      default:   data_mask = '1;
    endcase
  endfunction

endpackage

### hw/rtl/transactional_write_buffer.sv
// top level: deferred-store log with newest-first store-to-load forwarding
// store, clear, empty commit, filter-miss or empty-log load: result registered from the one working state
// searching load: result after LOAD_INIT and the LOAD_CMP search, one entry per cycle through the
//   single address comparator from the one read port; next beat taken once back in idle
// commit: count results back to back unless stalled, tlast on the last; next beat taken once back in idle
// result stalls hold the state; reset clears count, filter and control, log contents stay undefined
`timescale 1ns / 1ps

module transactional_write_buffer #(
  parameter int LOG_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // byte_addr[47:0], access_size[49:48], store_value[113:50], mem_word[177:114], zero pad
  input  logic [twb_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // mode[1:0]
  input  logic [1:0]                         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // word_addr[44:0], word_value[108:45], lane_mask[172:109], load_data[236:173], zero pad
  output logic [twb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // hit[0], filter_maybe[1], full_drop[2], empty_commit[3]
  output logic [twb_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);

  localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W = $clog2(LOG_DEPTH + 1);

  twb_pkg::state_e state_q, state_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [twb_pkg::FILT_W-1:0] filter_q, filter_d;

  // latched input beat
  logic [twb_pkg::BADDR_W-1:0] baddr_q;
  twb_pkg::size_e              size_q;
  logic [twb_pkg::DATA_W-1:0]  sval_q;
  logic [twb_pkg::DATA_W-1:0]  mword_q;

  // output register
  logic                           out_valid_q;
  logic [twb_pkg::OUT_TDATA_W-1:0] out_tdata_q;
  logic [twb_pkg::OUT_TUSER_W-1:0] out_tuser_q;
  logic                           out_tlast_q;

  logic                           out_we;
  logic [twb_pkg::WADDR_W-1:0]    o_waddr;
  logic [twb_pkg::DATA_W-1:0]     o_wvalue;
  logic [twb_pkg::DATA_W-1:0]     o_mask;
  logic [twb_pkg::DATA_W-1:0]     o_ldata;
  logic                           o_hit, o_maybe, o_drop, o_empty, o_last;

  logic                           in_accept, out_free;
  twb_pkg::mode_e                 in_mode;
  logic [twb_pkg::WADDR_W-1:0]    waddr;
  logic [5:0]                     shift;
  logic [twb_pkg::DATA_W-1:0]     dmask, st_mask, st_value, merged, ld_src, ld_data;
  logic [twb_pkg::FILT_IDX_W-1:0] fidx;
  logic                           maybe, full, empty, match, is_first, is_last;
  logic [IDX_W-1:0]               cnt_m1;
  logic                           wr_en;
  twb_pkg::entry_t                wr_entry, rd_entry;

  assign s_axis_tready_o = (state_q == twb_pkg::ST_IDLE);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign in_mode   = twb_pkg::mode_e'(s_axis_tuser_i);
  assign out_free  = !out_valid_q || m_axis_tready_i;

  assign waddr    = baddr_q[twb_pkg::BADDR_W-1:3];
  assign shift    = twb_pkg::lane_shift(baddr_q[2:0], size_q);
  assign dmask    = twb_pkg::data_mask(size_q);
  assign st_mask  = dmask << shift;
  assign st_value = (sval_q & dmask) << shift;
  assign fidx     = twb_pkg::filter_idx(baddr_q);
  assign maybe    = filter_q[fidx];
  assign full     = (count_q == CNT_W'(LOG_DEPTH));
  assign empty    = (count_q == '0);
  assign cnt_m1   = empty ? '0 : IDX_W'(count_q - 1'b1);

  // shared comparator against the entry read last cycle
  assign match    = (rd_entry.addr == waddr);
  assign merged   = (mword_q & ~rd_entry.mask) | (rd_entry.value & rd_entry.mask);
  assign is_first = (ptr_q == '0);
  assign is_last  = (CNT_W'(ptr_q) == CNT_W'(count_q - 1'b1));
  assign ld_src   = (state_q == twb_pkg::ST_LOAD_CMP && match) ? merged : mword_q;
  assign ld_data  = (ld_src >> shift) & dmask;

  assign wr_entry.addr  = waddr;
  assign wr_entry.value = st_value;
  assign wr_entry.mask  = st_mask;

  twb_log_mem #(
    .DEPTH (LOG_DEPTH)
  ) u_log_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_idx_i  (count_q[IDX_W-1:0]),
    .wr_data_i (wr_entry),
    .rd_idx_i  (ptr_d),
    .rd_data_o (rd_entry)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      twb_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_mode)
            twb_pkg::MODE_STORE:  state_d = twb_pkg::ST_STORE;
            twb_pkg::MODE_LOAD:   state_d = twb_pkg::ST_LOAD_INIT;
            twb_pkg::MODE_COMMIT: state_d = empty ? twb_pkg::ST_EMPTY : twb_pkg::ST_DRAIN;
            twb_pkg::MODE_CLEAR:  state_d = twb_pkg::ST_CLEAR;
            default:              state_d = twb_pkg::ST_IDLE;
          endcase
        end
      end
      twb_pkg::ST_LOAD_INIT: begin
        if (maybe && !empty) begin
          state_d = twb_pkg::ST_LOAD_CMP;
        end else if (out_free) begin
          state_d = twb_pkg::ST_IDLE;
        end
      end
      twb_pkg::ST_LOAD_CMP: begin
        if ((match || is_first) && out_free) begin
          state_d = twb_pkg::ST_IDLE;
        end
      end
      twb_pkg::ST_DRAIN: begin
        if (out_free && is_last) begin
          state_d = twb_pkg::ST_IDLE;
        end
      end
      twb_pkg::ST_STORE, twb_pkg::ST_EMPTY, twb_pkg::ST_CLEAR: begin
        if (out_free) begin
          state_d = twb_pkg::ST_IDLE;
        end
      end
      default: state_d = twb_pkg::ST_IDLE;
    endcase
  end

  // datapath control and result formation
  always_comb begin
    ptr_d    = ptr_q;
    count_d  = count_q;
    filter_d = filter_q;
    wr_en    = 1'b0;
    out_we   = 1'b0;
    o_waddr  = '0;
    o_wvalue = '0;
    o_mask   = '0;
    o_ldata  = '0;
    o_hit    = 1'b0;
    o_maybe  = 1'b0;
    o_drop   = 1'b0;
    o_empty  = 1'b0;
    o_last   = 1'b1;
    case (state_q)
      twb_pkg::ST_IDLE: begin
        if (in_accept) begin
          ptr_d = '0;
        end
      end
      twb_pkg::ST_STORE: begin
        if (out_free) begin
          out_we   = 1'b1;
          o_waddr  = waddr;
          o_wvalue = st_value;
          o_mask   = st_mask;
          o_drop   = full;
          if (!full) begin
            wr_en    = 1'b1;
            count_d  = count_q + 1'b1;
            filter_d = filter_q | (twb_pkg::FILT_W'(1) << fidx);
          end
        end
      end
      twb_pkg::ST_LOAD_INIT: begin
        // start the search at the newest entry
        ptr_d = cnt_m1;
        if (!(maybe && !empty) && out_free) begin
          out_we   = 1'b1;
          o_waddr  = waddr;
          o_wvalue = mword_q;
          o_ldata  = ld_data;
          o_maybe  = maybe;
        end
      end
      twb_pkg::ST_LOAD_CMP: begin
        if (match) begin
          if (out_free) begin
            out_we   = 1'b1;
            o_waddr  = waddr;
            o_wvalue = merged;
            o_mask   = rd_entry.mask;
            o_ldata  = ld_data;
            o_hit    = 1'b1;
            o_maybe  = 1'b1;
          end
        end else if (is_first) begin
          if (out_free) begin
            out_we   = 1'b1;
            o_waddr  = waddr;
            o_wvalue = mword_q;
            o_ldata  = ld_data;
            o_maybe  = 1'b1;
          end
        end else begin
          ptr_d = ptr_q - 1'b1;
        end
      end
      twb_pkg::ST_DRAIN: begin
        if (out_free) begin
          out_we   = 1'b1;
          o_waddr  = rd_entry.addr;
          o_wvalue = rd_entry.value;
          o_mask   = rd_entry.mask;
          o_last   = is_last;
          if (is_last) begin
            count_d  = '0;
            filter_d = '0;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end
      twb_pkg::ST_EMPTY: begin
        if (out_free) begin
          out_we   = 1'b1;
          o_empty  = 1'b1;
          filter_d = '0;
        end
      end
      twb_pkg::ST_CLEAR: begin
        if (out_free) begin
          out_we   = 1'b1;
          count_d  = '0;
          filter_d = '0;
        end
      end
      default: begin
        ptr_d = ptr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= twb_pkg::ST_IDLE;
      ptr_q       <= '0;
      count_q     <= '0;
      filter_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      count_q  <= count_d;
      filter_q <= filter_d;
      if (out_we) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      baddr_q <= s_axis_tdata_i[47:0];
      size_q  <= twb_pkg::size_e'(s_axis_tdata_i[49:48]);
      sval_q  <= s_axis_tdata_i[113:50];
      mword_q <= s_axis_tdata_i[177:114];
    end
    if (out_we) begin
      out_tdata_q <= {3'b000, o_ldata, o_mask, o_wvalue, o_waddr};
      out_tuser_q <= {o_empty, o_drop, o_maybe, o_hit};
      out_tlast_q <= o_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_tdata_q;
  assign m_axis_tuser_o  = out_tuser_q;
  assign m_axis_tlast_o  = out_tlast_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LOG_DEPTH))
    else $error("log count beyond depth");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_tuser_q[twb_pkg::TU_DROP]) |-> full)
    else $error("store dropped while log had room");

  a_hit_needs_filter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_tuser_q[twb_pkg::TU_HIT]) |-> out_tuser_q[twb_pkg::TU_MAYBE])
    else $error("load hit without filter bit");

  a_search_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == twb_pkg::ST_LOAD_CMP) |-> (CNT_W'(ptr_q) < count_q))
    else $error("search pointer outside filled log");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == twb_pkg::ST_DRAIN && out_we && is_last) |=> (count_q == '0 && filter_q == '0))
    else $error("log not emptied after commit drain");
`endif

endmodule

### hw/rtl/twb_log_mem.sv
// log storage with a write port and a registered read port, one write and one read per cycle
`timescale 1ns / 1ps

module twb_log_mem #(
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_idx_i,
  input  twb_pkg::entry_t                        wr_data_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_idx_i,
  output twb_pkg::entry_t                        rd_data_o
);

  twb_pkg::entry_t mem_q [DEPTH];
  twb_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_idx_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
